// File: rtl/core/pmbp_pkg.sv
// shared types, widths and constants of the mono mix block packer
// used by the mixer, the block buffer and the top level; no dependencies
package pmbp_pkg;

	localparam int NUM_CH_MAX  = 8;
	localparam int BLK_SAMPLES = 12;
	localparam int BLK_BYTES   = 16;
	localparam int HDR_BYTES   = 4;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 20;
	localparam int MAG_W    = 19;
	localparam int RECIP_W  = 21;
	localparam int RECIP_SH = 20;
	localparam int CH_W     = 4;
	localparam int SEEN_W   = 3;
	localparam int FILL_W   = 4;
	localparam int POS_W    = 4;
	localparam int BYTE_W   = 8;

	localparam logic [7:0] LOOP_BYTE  = 8'hFF;
	localparam logic [7:0] FINAL_BYTE = 8'h04;

	// register indexes on the configuration port
	localparam logic [1:0] REG_WIDTH_MODE = 2'd0;
	localparam logic [1:0] REG_CHANNELS   = 2'd1;
	localparam logic [1:0] REG_LOOP       = 2'd2;

	typedef struct packed {
		logic              done;
		logic              byte_valid;
		logic [BYTE_W-1:0] mono_byte;
	} mix_res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} emit_stat_t;

	// floor(2^RECIP_SH / n) for the channel counts in use
	function automatic logic [RECIP_W-1:0] recip(input logic [CH_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1: r = 21'd1048576;
			4'd2: r = 21'd524288;
			4'd3: r = 21'd349525;
			4'd4: r = 21'd262144;
			4'd5: r = 21'd209715;
			4'd6: r = 21'd174762;
			4'd7: r = 21'd149796;
			4'd8: r = 21'd131072;
			default: r = 21'd1048576;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/pmbp_mixer.sv
// frame accumulator and divide-by-channel-count pipeline, one mono byte per frame
// depends on pmbp_pkg
module pmbp_mixer import pmbp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                clear,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                wide_mode,
	input  logic [CH_W-1:0]     n_eff,
	output mix_res_t            res
);

	logic [SUM_W-1:0]  frame_sum_q;
	logic [SEEN_W-1:0] seen_q;

	logic [SAMPLE_W-1:0] s16;
	logic [SUM_W-1:0]    sum_new;
	logic [CH_W-1:0]     seen_new;
	logic                complete;

	assign s16      = wide_mode ? sample : {~sample[7], sample[6:0], 8'h00};
	assign sum_new  = frame_sum_q + {{(SUM_W-SAMPLE_W){s16[SAMPLE_W-1]}}, s16};
	assign seen_new = {1'b0, seen_q} + CH_W'(1);
	assign complete = seen_new >= n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_sum_q <= '0;
			seen_q      <= '0;
		end else if (clear) begin
			frame_sum_q <= '0;
			seen_q      <= '0;
		end else if (start) begin
			if (complete) begin
				frame_sum_q <= '0;
				seen_q      <= '0;
			end else begin
				frame_sum_q <= sum_new;
				seen_q      <= seen_new[SEEN_W-1:0];
			end
		end
	end

	// stage 1: completed frame sum
	logic             valid_s1, cmp_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [CH_W-1:0]  n_s1;

	// stage 2: magnitude and quotient estimate
	logic             valid_s2, cmp_s2, neg_s2;
	logic [MAG_W-1:0] mag_s2, q0_s2;
	logic [CH_W-1:0]  n_s2;

	// stage 3: result
	logic              valid_s3, cmp_s3;
	logic [BYTE_W-1:0] byte_s3;

	logic [SUM_W-1:0]         abs_sum;
	logic [MAG_W+RECIP_W-1:0] prod;
	logic [MAG_W+CH_W-1:0]    qn;
	logic [MAG_W-1:0]         rem, q_fix, mono;

	assign abs_sum = sum_s1[SUM_W-1] ? (~sum_s1 + SUM_W'(1)) : sum_s1;
	assign prod    = abs_sum[MAG_W-1:0] * recip(n_s1);

	// estimate is at most one short, one compare fixes it
	assign qn    = q0_s2 * n_s2;
	assign rem   = mag_s2 - qn[MAG_W-1:0];
	assign q_fix = q0_s2 + MAG_W'(rem >= {{(MAG_W-CH_W){1'b0}}, n_s2});
	assign mono  = neg_s2 ? (~q_fix + MAG_W'(1)) : q_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start & ~clear;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1  <= sum_new;
		cmp_s1  <= complete;
		n_s1    <= n_eff;
		neg_s2  <= sum_s1[SUM_W-1];
		mag_s2  <= abs_sum[MAG_W-1:0];
		q0_s2   <= prod[RECIP_SH+MAG_W-1:RECIP_SH];
		n_s2    <= n_s1;
		cmp_s2  <= cmp_s1;
		cmp_s3  <= cmp_s2;
		// floor shift by 8 of a truncated quotient
		byte_s3 <= mono[15:8];
	end

	assign res.done       = valid_s3;
	assign res.byte_valid = valid_s3 & cmp_s3;
	assign res.mono_byte  = byte_s3;

endmodule

// File: rtl/core/pmbp_block_buf.sv
// twelve-entry mono byte memory with fill count, block emission and output register
// depends on pmbp_pkg
module pmbp_block_buf import pmbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              emit_start,
	input  logic              emit_final,
	input  logic              loop_en,
	output logic [FILL_W-1:0] fill,
	output emit_stat_t        stat,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // out_byte
	output logic [4:0]        m_tuser,  // [3:0] byte_position, [4] final_block
	output logic              m_tlast   // last_of_block
);

	logic [BYTE_W-1:0] mem [BLK_SAMPLES];

	logic [FILL_W-1:0] fill_q;
	logic              emit_q, ld_q, final_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] rd_data_s1;

	logic              slot_free, load, last_pos;
	logic [POS_W-1:0]  rel;
	logic [BYTE_W-1:0] byte_sel;

	assign rel       = pos_q - POS_W'(HDR_BYTES);
	assign slot_free = ~m_tvalid | m_tready;
	assign load      = emit_q & ld_q & slot_free;
	assign last_pos  = pos_q == POS_W'(BLK_BYTES-1);

	always_comb begin
		case (pos_q)
			POS_W'(0): byte_sel = loop_en ? LOOP_BYTE : 8'h00;
			POS_W'(1): byte_sel = final_q ? FINAL_BYTE : 8'h00;
			POS_W'(2), POS_W'(3): byte_sel = 8'h00;
			// entries beyond the fill count read as zero padding
			default: byte_sel = (rel < fill_q) ? rd_data_s1 : 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[fill_q] <= wr_data;
		if (emit_q & ~ld_q)
			rd_data_s1 <= mem[(pos_q >= POS_W'(HDR_BYTES)) ? rel : '0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			emit_q  <= 1'b0;
			ld_q    <= 1'b0;
			final_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (load & last_pos)
				fill_q <= '0;
			else if (wr_en)
				fill_q <= fill_q + FILL_W'(1);

			if (emit_start) begin
				emit_q  <= 1'b1;
				ld_q    <= 1'b0;
				final_q <= emit_final;
				pos_q   <= '0;
			end else if (emit_q) begin
				if (!ld_q)
					ld_q <= 1'b1;
				else if (load) begin
					ld_q  <= 1'b0;
					pos_q <= pos_q + POS_W'(1);
					if (last_pos)
						emit_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (load)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= byte_sel;
			m_tuser <= {final_q, pos_q};
			m_tlast <= last_pos;
		end
	end

	assign fill      = fill_q;
	assign stat.busy = emit_q;
	assign stat.done = load & last_pos;

endmodule

// File: rtl/core/pcm_mono_mix_block_packer_unit.sv
// Mixes interleaved PCM channel samples (16-bit signed or 8-bit unsigned) into one
// signed mono byte per frame and sends every twelve bytes in a 16-byte block that starts
// with a 4-byte header. Each channel sample passes through the mixer pipeline
// (accumulate, reciprocal multiply, quotient correction) and a decision step before
// the next one is taken. In a block burst each of the 16 bytes needs a memory read
// and then an output load, and stalls on the output side hold the burst back.
// No input transfer is taken while a block is being sent. End of stream pads the
// pending bytes with zeros, marks the block final and drops an unfinished frame.
// depends on pmbp_pkg, pmbp_mixer, pmbp_block_buf
module pcm_mono_mix_block_packer_unit import pmbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample_raw
	input  logic        s_tlast,   // last_of_stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic [4:0]  m_tuser,   // [3:0] byte_position, [4] final_block
	output logic        m_tlast    // last_of_block
);

	localparam logic [1:0] S_IDLE      = 2'd0;
	localparam logic [1:0] S_EMIT_HELD = 2'd1;
	localparam logic [1:0] S_MIX       = 2'd2;
	localparam logic [1:0] S_EMIT_END  = 2'd3;

	logic [1:0] state_q;

	logic            width_mode_q, loop_en_q;
	logic [CH_W-1:0] channels_q;
	logic [CH_W-1:0] n_eff;

	logic [SAMPLE_W-1:0] raw_q;
	logic                last_q;

	logic              accept, cfg_wr;
	logic              mix_start, mix_clear;
	logic              emit_start, emit_final;
	logic [FILL_W-1:0] fill, fill_next;
	mix_res_t          mix;
	emit_stat_t        emit;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode_q <= 1'b1;
			channels_q   <= CH_W'(1);
			loop_en_q    <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WIDTH_MODE: width_mode_q <= pwdata[0];
				REG_CHANNELS:   channels_q   <= pwdata[CH_W-1:0];
				REG_LOOP:       loop_en_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH_MODE: prdata = {31'd0, width_mode_q};
			REG_CHANNELS:   prdata = {{(32-CH_W){1'b0}}, channels_q};
			REG_LOOP:       prdata = {31'd0, loop_en_q};
			default:        prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (channels_q == '0)
			n_eff = CH_W'(1);
		else if (channels_q > CH_W'(NUM_CH_MAX))
			n_eff = CH_W'(NUM_CH_MAX);
		else
			n_eff = channels_q;
	end

	assign s_tready  = state_q == S_IDLE;
	assign accept    = s_tvalid & s_tready;
	assign fill_next = fill + FILL_W'(mix.byte_valid);

	always_comb begin
		mix_start  = 1'b0;
		mix_clear  = 1'b0;
		emit_start = 1'b0;
		emit_final = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					// a held full block goes out first, final if this is the last sample
					if (fill == FILL_W'(BLK_SAMPLES)) begin
						emit_start = 1'b1;
						emit_final = s_tlast;
					end else
						mix_start = 1'b1;
				end
			end
			S_EMIT_HELD: begin
				if (emit.done) begin
					if (last_q)
						mix_clear = 1'b1;
					else
						mix_start = 1'b1;
				end
			end
			S_MIX: begin
				if (mix.done) begin
					if (last_q) begin
						mix_clear  = 1'b1;
						emit_start = fill_next != '0;
						emit_final = 1'b1;
					end else if (fill_next == FILL_W'(BLK_SAMPLES) && n_eff == CH_W'(1))
						emit_start = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else begin
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= emit_start ? S_EMIT_HELD : S_MIX;
				end
				S_EMIT_HELD: begin
					if (emit.done)
						state_q <= last_q ? S_IDLE : S_MIX;
				end
				S_MIX: begin
					if (mix.done)
						state_q <= emit_start ? S_EMIT_END : S_IDLE;
				end
				S_EMIT_END: begin
					if (emit.done)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q  <= s_tdata;
			last_q <= s_tlast;
		end
	end

	pmbp_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mix_start),
		.clear     (mix_clear),
		.sample    ((state_q == S_IDLE) ? s_tdata : raw_q),
		.wide_mode (width_mode_q),
		.n_eff     (n_eff),
		.res       (mix)
	);

	pmbp_block_buf u_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (mix.byte_valid),
		.wr_data    (mix.mono_byte),
		.emit_start (emit_start),
		.emit_final (emit_final),
		.loop_en    (loop_en_q),
		.fill       (fill),
		.stat       (emit),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// a byte is never appended to a full buffer
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		mix.byte_valid |-> fill < FILL_W'(BLK_SAMPLES))
		else $error("mono byte written into a full block buffer");

	// an emission is only started when none is running
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_start |-> !emit.busy)
		else $error("block emission restarted while busy");

	// mixer results only arrive while waiting for them
	a_mix_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mix.done |-> state_q == S_MIX)
		else $error("mixer result outside the mix state");

	// the buffer is empty once a block has gone out
	a_fill_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit.done |=> fill == '0)
		else $error("fill count not cleared after block emission");

endmodule

// File: test/tb_pcm_mono_mix_block_packer_unit.sv
// testbench for pcm_mono_mix_block_packer_unit: drives channel samples and register writes,
// predicts every block byte and checks each output transfer against it
// depends on pmbp_pkg and the rtl of the block
module tb_pcm_mono_mix_block_packer_unit import pmbp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] pos;
		logic       fin;
		logic       lst;
	} out_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;

	pcm_mono_mix_block_packer_unit dut (.*);

	always #2 clk = ~clk;

	// mixer state and register copy, reset values
	logic       cfg_wide = 1'b1;
	logic [3:0] cfg_chans = 4'd1;
	logic       cfg_loop = 1'b1;
	int         frame_acc = 0;
	int         frame_taken = 0;
	logic [7:0] mono_buf [BLK_SAMPLES];
	int         mono_fill = 0;

	out_byte_t block_bytes_due [$];
	int        mismatches = 0;
	int        items_sent = 0;
	int        snd_idle = 11;
	int        rcv_idle = 66;

	initial foreach (mono_buf[k]) mono_buf[k] = '0;

	function automatic int chans_in_use();
		if (cfg_chans == 4'd0) return 1;
		if (cfg_chans > NUM_CH_MAX) return NUM_CH_MAX;
		return int'(cfg_chans);
	endfunction

	task automatic queue_block(input logic fin);
		out_byte_t b;
		for (int i = 0; i < BLK_BYTES; i++) begin
			if (i == 0)
				b.data = cfg_loop ? LOOP_BYTE : 8'h00;
			else if (i == 1)
				b.data = fin ? FINAL_BYTE : 8'h00;
			else if (i < HDR_BYTES)
				b.data = 8'h00;
			else
				b.data = mono_buf[i - HDR_BYTES];
			b.pos = 4'(i);
			b.fin = fin;
			b.lst = (i == BLK_BYTES - 1);
			block_bytes_due.push_back(b);
		end
		foreach (mono_buf[k]) mono_buf[k] = '0;
		mono_fill = 0;
	endtask

	task automatic mix_sample(input logic [15:0] raw, input logic lst);
		int n, s, mono;
		bit held_sent;
		n = chans_in_use();
		held_sent = 0;
		// a held full block goes out first; a last sample then only closes it
		if (mono_fill >= BLK_SAMPLES) begin
			queue_block(lst);
			if (lst) begin
				frame_acc = 0;
				frame_taken = 0;
				return;
			end
			held_sent = 1;
		end
		if (cfg_wide)
			s = int'($signed(raw));
		else
			s = (int'(raw[7:0]) - 128) * 256;
		frame_acc += s;
		frame_taken++;
		if (frame_taken >= n) begin
			mono = frame_acc / n;
			mono_buf[mono_fill] = 8'(mono >>> 8);
			mono_fill++;
			frame_acc = 0;
			frame_taken = 0;
		end
		if (lst) begin
			if (mono_fill > 0)
				queue_block(1'b1);
			frame_acc = 0;
			frame_taken = 0;
			return;
		end
		if (mono_fill >= BLK_SAMPLES && n == 1 && !held_sent)
			queue_block(1'b0);
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	// output side: random stalls and comparison against the oldest expected byte
	always @(posedge clk) begin
		out_byte_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.data = m_tdata;
			got.pos = m_tuser[3:0];
			got.fin = m_tuser[4];
			got.lst = m_tlast;
			if (block_bytes_due.size() == 0) begin
				report_mismatch($sformatf("byte %02h pos %0d with nothing expected",
					got.data, got.pos));
			end else begin
				want = block_bytes_due.pop_front();
				if (got !== want)
					report_mismatch($sformatf(
						"got %02h pos %0d fin %0b last %0b, want %02h pos %0d fin %0b last %0b",
						got.data, got.pos, got.fin, got.lst,
						want.data, want.pos, want.fin, want.lst));
			end
		end
		m_tready <= ($urandom_range(99) >= rcv_idle);
	end

	task automatic send_sample(input logic [15:0] raw, input logic lst);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= raw;
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		mix_sample(raw, lst);
		items_sent++;
	endtask

	// wait for every expected byte, then let the mixer pipeline run dry
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (block_bytes_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WIDTH_MODE: cfg_wide = val[0];
			REG_CHANNELS:   cfg_chans = val[3:0];
			REG_LOOP:       cfg_loop = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic wide, input logic [3:0] ch, input logic lp);
		settle();
		write_reg(REG_WIDTH_MODE, {31'd0, wide});
		write_reg(REG_CHANNELS, {28'd0, ch});
		write_reg(REG_LOOP, {31'd0, lp});
	endtask

	// mostly one to three channels, now and then four to eight or the clamped counts
	function automatic logic [3:0] pick_chans();
		case ($urandom_range(9))
			0, 1, 2, 3: return 4'd1;
			4, 5:       return 4'd2;
			6:          return 4'd3;
			7:          return 4'($urandom_range(4, 8));
			8:          return 4'd0;
			default:    return 4'($urandom_range(9, 15));
		endcase
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// two-channel stream of twelve frames: the full block is held until the last
	// sample, which after a count change to one must still not start a frame
	task automatic test_held_block();
		logic [15:0] vals [24] = '{
			16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
			16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFE,
			16'hFF00, 16'h0000, 16'h0100, 16'h0101, 16'h8001, 16'hFFFF,
			16'h5555, 16'hAAAA, 16'h00FF, 16'h0000, 16'hFE01, 16'hFFFF};
		set_config(1'b1, 4'd2, 1'b1);
		foreach (vals[k])
			send_sample(vals[k], 1'b0);
		settle();
		write_reg(REG_CHANNELS, 32'd1);
		write_reg(REG_LOOP, 32'd0);
		send_sample(16'h1234, 1'b1);
	endtask

	// unsigned bytes with junk in the high bits; count lowered mid-frame,
	// then an unfinished frame dropped at the end
	task automatic test_eight_bit_frames();
		set_config(1'b0, 4'd4, 1'b0);
		send_sample(16'hA500, 1'b0);
		send_sample(16'h5AFF, 1'b0);
		settle();
		write_reg(REG_CHANNELS, 32'd2);
		send_sample(16'hC380, 1'b0);
		send_sample(16'h0011, 1'b1);
	endtask

	// zero acts as one channel; fifteen acts as eight, so a lone sample is an empty stream
	task automatic test_channel_clamp();
		set_config(1'b1, 4'd0, 1'b1);
		send_sample(16'h1280, 1'b1);
		set_config(1'b1, 4'd15, 1'b0);
		send_sample(16'h4000, 1'b1);
	endtask

	task automatic run_stream();
		int n, frames, total, split;
		set_config(1'($urandom_range(1)), pick_chans(), 1'($urandom_range(1)));
		n = chans_in_use();
		if (n == 1)
			frames = $urandom_range(1, 30);
		else if (n <= 3)
			frames = ($urandom_range(2) == 0) ? BLK_SAMPLES : $urandom_range(1, 14);
		else
			frames = $urandom_range(1, 3);
		total = frames * n;
		case ($urandom_range(3))
			0: total += $urandom_range(1, n);
			1: total = $urandom_range(1, total);
			default: ;
		endcase
		split = (total > 1 && $urandom_range(3) == 0) ? $urandom_range(1, total - 1) : 0;
		for (int k = 1; k <= total; k++) begin
			if (split != 0 && k == split + 1)
				set_config(1'($urandom_range(1)), pick_chans(), 1'($urandom_range(1)));
			send_sample(rand_sample(), k == total);
		end
	endtask

	task automatic test_random_streams(input int snd, input int rcv, input int quota);
		int goal;
		snd_idle = snd;
		rcv_idle = rcv;
		goal = items_sent + quota;
		while (items_sent < goal) run_stream();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_held_block();
		test_eight_bit_frames();
		test_channel_clamp();
		test_random_streams(11, 66, 45);
		test_random_streams(66, 11, 45);
		test_random_streams(0, 0, 45);
		settle();
		repeat (24) @(posedge clk);
		if (mismatches == 0 && block_bytes_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
